@@ hdl/odo_pkg.sv @@
// Shared types and constants for the odometry move block.
package odo_pkg;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_IGNORE = 2'd2
  } kind_t;

  typedef struct packed {
    logic  latch;
    logic  hmul;
    logic  hadd;
    logic  idx;
    logic  rsin;
    logic  rcos;
    logic  mul;
    logic  commit;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic active;
  } stat_t;

  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_TARGET = 2'd1;
  localparam logic [1:0] CAUSE_BUMP   = 2'd2;
  localparam logic [1:0] CAUSE_CLIFF  = 2'd3;

  localparam logic [1:0] REG_REVERSE = 2'd0;
  localparam logic [1:0] REG_BRIGHT  = 2'd1;
  localparam logic [1:0] REG_HOLE    = 2'd2;
  localparam logic [1:0] REG_GAIN    = 2'd3;

  localparam logic [11:0] RESET_BRIGHT = 12'd2600;
  localparam logic [11:0] RESET_HOLE   = 12'd160;
  localparam logic [15:0] RESET_GAIN   = 16'd5051;

endpackage

@@ hdl/odo_ctrl.sv @@
// Controller state machine that sequences one item through the odometry datapath.
module odo_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_action,
  output logic           out_valid,
  input  logic           out_ready,
  input  odo_pkg::stat_t stat,
  output odo_pkg::cmd_t  cmd
);
  import odo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_HMUL, S_HADD, S_IDX, S_RSIN, S_RCOS, S_MUL, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    cmd        = '0;
    cmd.kind   = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (!in_action) begin
            kind_nxt  = KIND_START;
            state_nxt = S_DONE;
          end else if (stat.active) begin
            kind_nxt  = KIND_TICK;
            state_nxt = S_HMUL;
          end else begin
            kind_nxt  = KIND_IGNORE;
            state_nxt = S_DONE;
          end
        end
      end
      S_HMUL: begin
        cmd.hmul  = 1'b1;
        state_nxt = S_HADD;
      end
      S_HADD: begin
        cmd.hadd  = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = S_RSIN;
      end
      S_RSIN: begin
        cmd.rsin  = 1'b1;
        state_nxt = S_RCOS;
      end
      S_RCOS: begin
        cmd.rcos  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= KIND_IGNORE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("state committed while a result beat was still pending");

  a_drop_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready))
    else $error("result beat dropped without being taken");

  a_latch_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> (state_r != S_IDLE))
    else $error("accepted beat did not start processing");

endmodule

@@ hdl/odo_dp.sv @@
// Datapath holding the pose, move state, configuration and sine table.
module odo_dp #(
  parameter int ANGLE_BITS   = 16,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  odo_pkg::cmd_t      cmd,
  output odo_pkg::stat_t     stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [15:0]        in_target_mm,
  input  logic [15:0]        in_left_count,
  input  logic [15:0]        in_right_count,
  input  logic signed [15:0] in_step_mm,
  input  logic               in_bump_left,
  input  logic               in_bump_right,
  input  logic [11:0]        in_cliff_front_left,
  input  logic [11:0]        in_cliff_front_right,
  input  logic [11:0]        in_cliff_side_left,
  input  logic [11:0]        in_cliff_side_right,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_heading,
  output logic signed [31:0] out_travelled_mm,
  output logic               out_moving,
  output logic [1:0]         out_stop_cause
);
  import odo_pkg::*;

  localparam int HW = ANGLE_BITS + 8;
  localparam int IW = $clog2(4 * SINE_ENTRIES);
  localparam int AW = $clog2(SINE_ENTRIES);
  localparam logic [IW:0]   FOUR_N  = (IW + 1)'(4 * SINE_ENTRIES);
  localparam logic [IW:0]   ONE_N   = (IW + 1)'(SINE_ENTRIES);
  localparam logic [IW:0]   TWO_N   = (IW + 1)'(2 * SINE_ENTRIES);
  localparam logic [IW:0]   THREE_N = (IW + 1)'(3 * SINE_ENTRIES);
  localparam logic [15:0]   Q15_ONE = 16'd32767;

  typedef logic [15:0] rom_t [SINE_ENTRIES];

  function automatic logic [15:0] sine_entry(input int i);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    x    = (64'd1686629713 * 64'(i)) / SINE_ENTRIES;
    term = x;
    sum  = longint'(x);
    term = (((term * x) >> 30) * x) >> 30; term = term / 6;   sum = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 20;  sum = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 42;  sum = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 72;  sum = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 110; sum = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 156; sum = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 210; sum = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30; term = term / 272; sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Returns {negate, full scale, table address} for a table index.
  function automatic logic [AW+1:0] qdec(input logic [IW-1:0] v);
    logic [IW:0] r;
    logic [IW:0] j;
    logic [1:0]  q;
    logic        full;
    if ({1'b0, v} < ONE_N) begin
      q = 2'd0; r = {1'b0, v};
    end else if ({1'b0, v} < TWO_N) begin
      q = 2'd1; r = {1'b0, v} - ONE_N;
    end else if ({1'b0, v} < THREE_N) begin
      q = 2'd2; r = {1'b0, v} - TWO_N;
    end else begin
      q = 2'd3; r = {1'b0, v} - THREE_N;
    end
    j    = q[0] ? (ONE_N - r) : r;
    full = (j == ONE_N);
    return {q[1], full, full ? {AW{1'b0}} : j[AW-1:0]};
  endfunction

  function automatic logic signed [16:0] trig(input logic [15:0] m, input logic neg,
                                              input logic full);
    logic signed [16:0] mag;
    mag = $signed({1'b0, full ? Q15_ONE : m});
    return neg ? -mag : mag;
  endfunction

  function automatic logic [31:0] to_q8(input logic signed [32:0] p);
    logic signed [32:0] s;
    s = p + 33'sd64;
    s = s >>> 7;
    return s[31:0];
  endfunction

  function automatic logic cliff_bad(input logic [11:0] v, input logic [11:0] hi,
                                     input logic [11:0] lo);
    return (v > hi) || (v < lo);
  endfunction

  logic               reverse_r;
  logic [11:0]        bright_r, hole_r;
  logic [15:0]        gain_r;

  logic signed [31:0] pose_x_r, pose_y_r, travel_r;
  logic [HW-1:0]      pose_heading_r;
  logic [15:0]        target_r, left_base_r, right_base_r;
  logic               active_r;
  logic [1:0]         cause_r;

  logic [15:0]        lat_target_r, lat_left_r, lat_right_r;
  logic signed [15:0] lat_step_r;
  logic               lat_bump_r;
  logic [11:0]        lat_cfl_r, lat_cfr_r, lat_csl_r, lat_csr_r;

  logic signed [32:0] turn_r;
  logic [HW-1:0]      head_new_r;
  logic [IW-1:0]      idx_r;
  logic [15:0]        rom_q_r;
  logic               sin_neg_r, sin_full_r, cos_neg_r, cos_full_r;
  logic signed [16:0] sin_r;
  logic signed [32:0] mx_r, my_r;

  logic [15:0]                  dl, dr;
  logic signed [16:0]           diff;
  logic [ANGLE_BITS+IW:0]       prod;
  logic [IW:0]                  cidx;
  logic [AW+1:0]                sdec, cdec;
  logic [AW-1:0]                rd_addr;
  logic [31:0]                  mx, my;
  logic signed [16:0]           step_dir;
  logic signed [33:0]           t_wide;
  logic signed [31:0]           t_sat;
  logic                         cliff_any;
  logic [1:0]                   cause;

  always_comb begin
    dl       = lat_left_r - left_base_r;
    dr       = lat_right_r - right_base_r;
    diff     = reverse_r ? ($signed({dl[15], dl}) - $signed({dr[15], dr}))
                         : ($signed({dr[15], dr}) - $signed({dl[15], dl}));
    prod     = (ANGLE_BITS + IW + 1)'(head_new_r[HW-1:8]) * (ANGLE_BITS + IW + 1)'(FOUR_N);
    cidx     = ({1'b0, idx_r} >= THREE_N) ? ({1'b0, idx_r} - THREE_N) : ({1'b0, idx_r} + ONE_N);
    sdec     = qdec(idx_r);
    cdec     = qdec(cidx[IW-1:0]);
    rd_addr  = cmd.rsin ? sdec[AW-1:0] : cdec[AW-1:0];
    mx       = to_q8(mx_r);
    my       = to_q8(my_r);
    step_dir = reverse_r ? -$signed({lat_step_r[15], lat_step_r})
                         : $signed({lat_step_r[15], lat_step_r});
    t_wide   = $signed({{2{travel_r[31]}}, travel_r}) + 34'(step_dir);
    if (t_wide > 34'sd2147483647) begin
      t_sat = 32'sh7FFF_FFFF;
    end else if (t_wide < -34'sd2147483648) begin
      t_sat = 32'sh8000_0000;
    end else begin
      t_sat = t_wide[31:0];
    end
    cliff_any = cliff_bad(lat_cfl_r, bright_r, hole_r) || cliff_bad(lat_cfr_r, bright_r, hole_r) ||
                cliff_bad(lat_csl_r, bright_r, hole_r) || cliff_bad(lat_csr_r, bright_r, hole_r);
    if (!reverse_r && lat_bump_r) begin
      cause = CAUSE_BUMP;
    end else if (!reverse_r && cliff_any) begin
      cause = CAUSE_CLIFF;
    end else if ($signed({t_sat[31], t_sat}) >= $signed({17'd0, target_r})) begin
      cause = CAUSE_TARGET;
    end else begin
      cause = CAUSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r <= 1'b0;
      bright_r  <= RESET_BRIGHT;
      hole_r    <= RESET_HOLE;
      gain_r    <= RESET_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REVERSE: reverse_r <= cfg_data[0];
        REG_BRIGHT:  bright_r  <= cfg_data[11:0];
        REG_HOLE:    hole_r    <= cfg_data[11:0];
        REG_GAIN:    gain_r    <= cfg_data;
        default:     reverse_r <= reverse_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_target_r <= in_target_mm;
      lat_left_r   <= in_left_count;
      lat_right_r  <= in_right_count;
      lat_step_r   <= in_step_mm;
      lat_bump_r   <= in_bump_left | in_bump_right;
      lat_cfl_r    <= in_cliff_front_left;
      lat_cfr_r    <= in_cliff_front_right;
      lat_csl_r    <= in_cliff_side_left;
      lat_csr_r    <= in_cliff_side_right;
    end
    if (cmd.hmul) begin
      turn_r <= 33'(diff) * $signed({17'd0, gain_r});
    end
    if (cmd.hadd) begin
      head_new_r <= pose_heading_r + turn_r[HW-1:0];
    end
    if (cmd.idx) begin
      idx_r <= prod[ANGLE_BITS +: IW];
    end
    if (cmd.rsin || cmd.rcos) begin
      rom_q_r <= SINE_ROM[rd_addr];
    end
    if (cmd.rsin) begin
      sin_neg_r  <= sdec[AW+1];
      sin_full_r <= sdec[AW];
    end
    if (cmd.rcos) begin
      cos_neg_r  <= cdec[AW+1];
      cos_full_r <= cdec[AW];
      sin_r      <= trig(rom_q_r, sin_neg_r, sin_full_r);
    end
    if (cmd.mul) begin
      mx_r <= 33'(lat_step_r) * 33'(trig(rom_q_r, cos_neg_r, cos_full_r));
      my_r <= 33'(lat_step_r) * 33'(sin_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r       <= '0;
      pose_y_r       <= '0;
      pose_heading_r <= '0;
      travel_r       <= '0;
      target_r       <= '0;
      left_base_r    <= '0;
      right_base_r   <= '0;
      active_r       <= 1'b0;
      cause_r        <= CAUSE_NONE;
    end else if (cmd.commit) begin
      case (cmd.kind)
        KIND_START: begin
          target_r     <= lat_target_r;
          left_base_r  <= lat_left_r;
          right_base_r <= lat_right_r;
          travel_r     <= '0;
          active_r     <= (lat_target_r != 16'd0);
          cause_r      <= (lat_target_r != 16'd0) ? CAUSE_NONE : CAUSE_TARGET;
        end
        KIND_TICK: begin
          pose_heading_r <= head_new_r;
          left_base_r    <= lat_left_r;
          right_base_r   <= lat_right_r;
          pose_x_r       <= reverse_r ? (pose_x_r - $signed(mx)) : (pose_x_r + $signed(mx));
          pose_y_r       <= reverse_r ? (pose_y_r - $signed(my)) : (pose_y_r + $signed(my));
          travel_r       <= t_sat;
          if (cause != CAUSE_NONE) begin
            active_r <= 1'b0;
            cause_r  <= cause;
          end
        end
        default: active_r <= active_r;
      endcase
    end
  end

  generate
    if (ANGLE_BITS >= 16) begin : g_head_wide
      assign out_heading = pose_heading_r[HW-1 -: 16];
    end else begin : g_head_narrow
      assign out_heading = {pose_heading_r[HW-1:8], {(16 - ANGLE_BITS){1'b0}}};
    end
  endgenerate

  assign stat.active      = active_r;
  assign out_pos_x        = pose_x_r;
  assign out_pos_y        = pose_y_r;
  assign out_travelled_mm = travel_r;
  assign out_moving       = active_r;
  assign out_stop_cause   = cause_r;

  a_active_no_cause: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cause_r == CAUSE_NONE))
    else $error("move is active but a stop cause is recorded");

  a_heading_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(pose_heading_r))
    else $error("heading changed outside a commit");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cmd.kind == KIND_START) |=> (travel_r == 32'sd0))
    else $error("start did not clear the travelled sum");

endmodule

@@ hdl/odometry_move_with_hazard_stop.sv @@
// Top level of the dead-reckoning odometry block with hazard stop.
// A start beat or a tick while idle goes from acceptance straight to its commit.
// A tick during a move passes through these steps in order before its result: heading
// multiply, heading add, index multiply, two sine table reads on one port, step multiplies, commit.
// One item is in flight at a time; a commit waits while the previous result beat is not taken.
// Synchronous active-low reset clears the pose, move state and configuration to defaults.
module odometry_move_with_hazard_stop #(
  parameter int ANGLE_BITS   = 16,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [15:0]        in_target_mm,
  input  logic [15:0]        in_left_count,
  input  logic [15:0]        in_right_count,
  input  logic signed [15:0] in_step_mm,
  input  logic               in_bump_left,
  input  logic               in_bump_right,
  input  logic [11:0]        in_cliff_front_left,
  input  logic [11:0]        in_cliff_front_right,
  input  logic [11:0]        in_cliff_side_left,
  input  logic [11:0]        in_cliff_side_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_heading,
  output logic signed [31:0] out_travelled_mm,
  output logic               out_moving,
  output logic [1:0]         out_stop_cause
);
  import odo_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  odo_dp #(
    .ANGLE_BITS   (ANGLE_BITS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_target_mm         (in_target_mm),
    .in_left_count        (in_left_count),
    .in_right_count       (in_right_count),
    .in_step_mm           (in_step_mm),
    .in_bump_left         (in_bump_left),
    .in_bump_right        (in_bump_right),
    .in_cliff_front_left  (in_cliff_front_left),
    .in_cliff_front_right (in_cliff_front_right),
    .in_cliff_side_left   (in_cliff_side_left),
    .in_cliff_side_right  (in_cliff_side_right),
    .out_pos_x            (out_pos_x),
    .out_pos_y            (out_pos_y),
    .out_heading          (out_heading),
    .out_travelled_mm     (out_travelled_mm),
    .out_moving           (out_moving),
    .out_stop_cause       (out_stop_cause)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the odometry move block with hazard stop.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import odo_pkg::*;

  typedef struct {
    logic              action;
    logic [15:0]       target_mm;
    logic [15:0]       left_count;
    logic [15:0]       right_count;
    logic signed [15:0] step_mm;
    logic              bump_left;
    logic              bump_right;
    logic [11:0]       cliff_fl;
    logic [11:0]       cliff_fr;
    logic [11:0]       cliff_sl;
    logic [11:0]       cliff_sr;
  } sensor_beat_t;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
    logic [31:0] travelled;
    logic        moving;
    logic [1:0]  cause;
  } pose_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_REVERSE;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [15:0] in_target_mm = '0, in_left_count = '0, in_right_count = '0;
  logic signed [15:0] in_step_mm = '0;
  logic in_bump_left = 1'b0, in_bump_right = 1'b0;
  logic [11:0] in_cliff_front_left = '0, in_cliff_front_right = '0;
  logic [11:0] in_cliff_side_left = '0, in_cliff_side_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_travelled_mm;
  logic [15:0] out_heading;
  logic out_moving;
  logic [1:0] out_stop_cause;

  odometry_move_with_hazard_stop uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  int          sine_q15_lut [1024];
  logic [31:0] px, py;
  logic [23:0] hd;
  int          travel;
  logic [15:0] target_hold, lbase, rbase;
  logic        moving_now;
  logic [1:0]  cause_now;
  logic        rev_cfg;
  logic [11:0] bright_cfg, hole_cfg;
  logic [15:0] gain_cfg;

  pose_report_t expected_poses[$];
  int errors = 0;
  bit calm = 0;
  int idle_cycles = 0;
  logic [15:0] lc_now = '0, rc_now = '0;

  function automatic void build_sine();
    longint unsigned x, term;
    longint sum, v;
    for (int i = 0; i < 1024; i++) begin
      x = (64'd1686629713 * i) / 1024;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * k) * (2 * k + 1));
        if (k % 2) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum * 32767 + (64'd1 << 29)) >>> 30;
      if (v > 32767) v = 32767;
      sine_q15_lut[i] = int'(v);
    end
  endfunction

  function automatic int quarter_wave(int unsigned j);
    return (j >= 1024) ? 32767 : sine_q15_lut[j];
  endfunction

  function automatic int sine_of(int unsigned idx);
    int unsigned r;
    r = idx % 1024;
    case ((idx / 1024) % 4)
      0: return quarter_wave(r);
      1: return quarter_wave(1024 - r);
      2: return -quarter_wave(r);
      default: return -quarter_wave(1024 - r);
    endcase
  endfunction

  function automatic logic [31:0] round_to_q8(longint p);
    longint q;
    q = (p + 64) >>> 7;
    return q[31:0];
  endfunction

  function automatic bit cliff_outside(logic [11:0] v);
    return (v > bright_cfg) || (v < hole_cfg);
  endfunction

  function automatic void reset_predictor();
    px = '0; py = '0; hd = '0; travel = 0;
    target_hold = '0; lbase = '0; rbase = '0;
    moving_now = 1'b0; cause_now = CAUSE_NONE;
    rev_cfg = 1'b0; bright_cfg = RESET_BRIGHT; hole_cfg = RESET_HOLE; gain_cfg = RESET_GAIN;
  endfunction

  function automatic pose_report_t predict_pose(sensor_beat_t b);
    pose_report_t r;
    logic signed [15:0] dl16, dr16;
    longint turn, step, t;
    int unsigned idx;
    int s, c;
    logic [31:0] mx, my;
    logic [1:0] cause;
    if (b.action == 1'b0) begin
      target_hold = b.target_mm;
      lbase = b.left_count;
      rbase = b.right_count;
      travel = 0;
      moving_now = (b.target_mm != 0);
      cause_now = moving_now ? CAUSE_NONE : CAUSE_TARGET;
    end else if (moving_now) begin
      dl16 = b.left_count - lbase;
      dr16 = b.right_count - rbase;
      turn = rev_cfg ? longint'(dl16) - longint'(dr16) : longint'(dr16) - longint'(dl16);
      turn = turn * longint'(gain_cfg);
      t = longint'(hd) + turn;
      hd = t[23:0];
      lbase = b.left_count;
      rbase = b.right_count;
      step = longint'(b.step_mm);
      idx = {20'd0, hd[23:12]};
      s = sine_of(idx);
      c = sine_of((idx + 1024) % 4096);
      mx = round_to_q8(step * c);
      my = round_to_q8(step * s);
      if (rev_cfg) begin
        px = px - mx; py = py - my;
      end else begin
        px = px + mx; py = py + my;
      end
      t = longint'(travel) + (rev_cfg ? -step : step);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      travel = int'(t);
      cause = CAUSE_NONE;
      if (!rev_cfg && (b.bump_left || b.bump_right)) cause = CAUSE_BUMP;
      else if (!rev_cfg && (cliff_outside(b.cliff_fl) || cliff_outside(b.cliff_fr) ||
                            cliff_outside(b.cliff_sl) || cliff_outside(b.cliff_sr)))
        cause = CAUSE_CLIFF;
      else if (longint'(travel) >= longint'(target_hold)) cause = CAUSE_TARGET;
      if (cause != CAUSE_NONE) begin
        moving_now = 1'b0;
        cause_now = cause;
      end
    end
    r.pos_x = px; r.pos_y = py; r.heading = hd[23:8];
    r.travelled = travel; r.moving = moving_now; r.cause = cause_now;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REVERSE: rev_cfg = cfg_data[0];
          REG_BRIGHT:  bright_cfg = cfg_data[11:0];
          REG_HOLE:    hole_cfg = cfg_data[11:0];
          REG_GAIN:    gain_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        sensor_beat_t b;
        b.action = in_action; b.target_mm = in_target_mm;
        b.left_count = in_left_count; b.right_count = in_right_count;
        b.step_mm = in_step_mm; b.bump_left = in_bump_left; b.bump_right = in_bump_right;
        b.cliff_fl = in_cliff_front_left; b.cliff_fr = in_cliff_front_right;
        b.cliff_sl = in_cliff_side_left; b.cliff_sr = in_cliff_side_right;
        expected_poses.push_back(predict_pose(b));
      end
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      pose_report_t e;
      if (expected_poses.size() == 0) begin
        $display("result beat with nothing expected at %0t", $realtime);
        errors++;
      end else begin
        e = expected_poses.pop_front();
        if (out_pos_x !== e.pos_x) report_mismatch("pos_x", out_pos_x, e.pos_x);
        if (out_pos_y !== e.pos_y) report_mismatch("pos_y", out_pos_y, e.pos_y);
        if (out_heading !== e.heading)
          report_mismatch("heading", 32'(out_heading), 32'(e.heading));
        if (out_travelled_mm !== e.travelled)
          report_mismatch("travelled_mm", out_travelled_mm, e.travelled);
        if (out_moving !== e.moving)
          report_mismatch("moving", 32'(out_moving), 32'(e.moving));
        if (out_stop_cause !== e.cause)
          report_mismatch("stop_cause", 32'(out_stop_cause), 32'(e.cause));
      end
    end
  end

  always @(negedge clk) begin
    if (calm || $urandom_range(0, 4) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("odometry_move_with_hazard_stop test failed");
      $finish;
    end
  end

  task automatic send_beat(sensor_beat_t b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_action = b.action; in_target_mm = b.target_mm;
    in_left_count = b.left_count; in_right_count = b.right_count;
    in_step_mm = b.step_mm; in_bump_left = b.bump_left; in_bump_right = b.bump_right;
    in_cliff_front_left = b.cliff_fl; in_cliff_front_right = b.cliff_fr;
    in_cliff_side_left = b.cliff_sl; in_cliff_side_right = b.cliff_sr;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic sensor_beat_t start_beat(logic [15:0] target);
    sensor_beat_t b;
    b = '{default: '0};
    b.target_mm = target;
    lc_now = 16'($urandom); rc_now = 16'($urandom);
    b.left_count = lc_now; b.right_count = rc_now;
    b.step_mm = 16'($urandom); b.cliff_fl = 12'($urandom); b.cliff_fr = 12'($urandom);
    b.cliff_sl = 12'($urandom); b.cliff_sr = 12'($urandom);
    b.bump_left = 1'($urandom); b.bump_right = 1'($urandom);
    return b;
  endfunction

  // A tick with cliff signals drawn between the hole and bright thresholds and no bump.
  function automatic sensor_beat_t clean_tick(int max_count, int max_step);
    sensor_beat_t b;
    b = '{default: '0};
    b.action = 1'b1;
    lc_now = lc_now + 16'($urandom_range(0, 2 * max_count) - max_count);
    rc_now = rc_now + 16'($urandom_range(0, 2 * max_count) - max_count);
    b.left_count = lc_now; b.right_count = rc_now;
    b.step_mm = 16'($urandom_range(0, max_step));
    b.target_mm = 16'($urandom);
    b.cliff_fl = 12'($urandom_range(bright_cfg, hole_cfg));
    b.cliff_fr = 12'($urandom_range(bright_cfg, hole_cfg));
    b.cliff_sl = 12'($urandom_range(bright_cfg, hole_cfg));
    b.cliff_sr = 12'($urandom_range(bright_cfg, hole_cfg));
    return b;
  endfunction

  function automatic sensor_beat_t noise_beat();
    sensor_beat_t b;
    b.action = 1'($urandom); b.target_mm = 16'($urandom);
    b.left_count = 16'($urandom); b.right_count = 16'($urandom);
    b.step_mm = 16'($urandom);
    b.bump_left = 1'($urandom); b.bump_right = 1'($urandom);
    b.cliff_fl = 12'($urandom); b.cliff_fr = 12'($urandom);
    b.cliff_sl = 12'($urandom); b.cliff_sr = 12'($urandom);
    return b;
  endfunction

  task automatic test_directed();
    sensor_beat_t b;
    send_beat(start_beat(16'd0));
    b = clean_tick(10, 50);
    send_beat(b);
    send_beat(start_beat(16'd300));
    send_beat(clean_tick(40, 100));
    b = clean_tick(0, 0);
    b.left_count = lc_now + 16'h8000; b.right_count = rc_now + 16'h7FFF;
    lc_now = b.left_count; rc_now = b.right_count;
    b.step_mm = 16'sh7FFF;
    send_beat(b);
    send_beat(start_beat(16'hFFFF));
    b = clean_tick(5, 10);
    b.step_mm = 16'sh8000;
    send_beat(b);
    b = clean_tick(5, 10);
    b.bump_left = 1'b1; b.cliff_fl = 12'd0;
    send_beat(b);
    send_beat(start_beat(16'd5000));
    b = clean_tick(5, 10);
    b.bump_right = 1'b1;
    send_beat(b);
    send_beat(start_beat(16'd5000));
    b = clean_tick(5, 10);
    b.cliff_sr = 12'hFFF;
    send_beat(b);
    send_beat(start_beat(16'd5000));
    b = clean_tick(5, 10);
    b.cliff_fr = 12'd0;
    send_beat(b);
    send_beat(start_beat(16'd5000));
    send_beat(clean_tick(5, 10));
    send_beat(start_beat(16'd20));
    b = clean_tick(5, 0);
    b.step_mm = 16'sd20;
    send_beat(b);
    send_beat(clean_tick(5, 10));
  endtask

  task automatic test_registers();
    sensor_beat_t b;
    write_reg(REG_GAIN, 16'hFFFF);
    write_reg(REG_BRIGHT, 16'hFFFF);
    write_reg(REG_HOLE, 16'h0000);
    send_beat(start_beat(16'd2000));
    repeat (4) send_beat(clean_tick(3000, 400));
    write_reg(REG_REVERSE, 16'hFFFF);
    repeat (3) send_beat(clean_tick(3000, 400));
    b = clean_tick(100, 100);
    b.bump_left = 1'b1; b.cliff_fl = 12'd0;
    send_beat(b);
    b = clean_tick(100, 0);
    b.step_mm = -16'sd3000;
    send_beat(b);
    write_reg(REG_GAIN, 16'h0000);
    write_reg(REG_BRIGHT, 16'h0000);
    write_reg(REG_HOLE, 16'h0FFF);
    send_beat(start_beat(16'd100));
    send_beat(clean_tick(500, 50));
    write_reg(REG_REVERSE, 16'h0000);
    send_beat(clean_tick(500, 50));
  endtask

  task automatic random_moves(int beats);
    int sent;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(noise_beat());
        sent++;
      end else begin
        int n;
        sensor_beat_t b;
        n = $urandom_range(2, 20);
        send_beat(start_beat($urandom_range(0, 7) == 0 ? 16'($urandom) :
                             16'($urandom_range(1, 4000))));
        sent++;
        repeat (n) begin
          b = clean_tick($urandom_range(0, 3) == 0 ? 32767 : 200,
                         $urandom_range(0, 5) == 0 ? 32767 : 400);
          if ($urandom_range(0, 30) == 0) b.bump_left = 1'b1;
          if ($urandom_range(0, 30) == 0) b.bump_right = 1'b1;
          if ($urandom_range(0, 30) == 0) b.cliff_sl = 12'($urandom);
          if ($urandom_range(0, 15) == 0) b.step_mm = 16'($urandom);
          send_beat(b);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random();
    write_reg(REG_GAIN, RESET_GAIN);
    write_reg(REG_BRIGHT, 16'(RESET_BRIGHT));
    write_reg(REG_HOLE, 16'(RESET_HOLE));
    random_moves(200);
    write_reg(REG_REVERSE, 16'd1);
    write_reg(REG_GAIN, 16'($urandom));
    random_moves(120);
    write_reg(REG_REVERSE, 16'd0);
    write_reg(REG_BRIGHT, 16'($urandom_range(2000, 4095)));
    write_reg(REG_HOLE, 16'($urandom_range(0, 1500)));
    random_moves(100);
  endtask

  // Reverse move with the largest step on every tick and no idling, then forward random moves.
  task automatic test_travel_floor();
    sensor_beat_t b;
    calm = 1;
    write_reg(REG_REVERSE, 16'd1);
    send_beat(start_beat(16'hFFFF));
    repeat (40) begin
      b = clean_tick(2, 0);
      b.step_mm = 16'sh7FFF;
      send_beat(b);
    end
    write_reg(REG_REVERSE, 16'd0);
    random_moves(60);
  endtask

  initial begin
    build_sine();
    reset_predictor();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_registers();
    test_random();
    test_travel_floor();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_poses.size() == 0)
      $display("odometry_move_with_hazard_stop test passed");
    else
      $display("odometry_move_with_hazard_stop test failed");
    $finish;
  end

endmodule
